// ===== rtl/core/kss_pkg.sv =====
// kss_pkg: shared constants, status codes and state encoding for the
// kth largest subset sum core. no dependencies.
package kss_pkg;

    localparam int DEF_MAX_ITEMS = 1024;
    localparam int DEF_MAX_RANK  = 2048;
    localparam int VALUE_W       = 32;
    localparam int RANK_W        = 12;
    localparam int KSUM_W        = 42;
    localparam int STATUS_W      = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_TOO_MANY     = 2'd1,
        ST_RANK_RANGE   = 2'd2,
        ST_RANK_SUBSETS = 2'd3
    } t_status;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_INS_CMP  = 14'b00000000000010,
        S_INS_WR   = 14'b00000000000100,
        S_CHECK    = 14'b00000000001000,
        S_POP_RD   = 14'b00000000010000,
        S_POP_TOP  = 14'b00000000100000,
        S_POP_LAST = 14'b00000001000000,
        S_POP_M1   = 14'b00000010000000,
        S_POP_M2   = 14'b00000100000000,
        S_DN       = 14'b00001000000000,
        S_UP_RD    = 14'b00010000000000,
        S_UP       = 14'b00100000000000,
        S_UP_WR    = 14'b01000000000000,
        S_FIN      = 14'b10000000000000
    } t_state;

endpackage

// ===== rtl/core/kth_largest_subset_sum_core.sv =====
// kth_largest_subset_sum_core: loads signed values into a sorted magnitude
// store and runs a min-heap over subset sums. depends on kss_pkg, kss_heap_ram.
//
// channel   direction  handshake                 payload
// input     in         start & !busy             i_value, i_rank, i_last
// result    out        o_valid, one cycle        o_kth_sum, o_status
//
// the first item of a set is written straight into the store; any other item
// shifts each stored magnitude larger than it up one place (insertion into the sorted store).
// after the last item the core checks the set, pops the heap (read the top, sift down,
// then sift up a second node), reads the final top and registers the result.
// reset clears counts and flags; memories need no clearing.
// results cannot be stalled; o_valid is high for exactly one cycle.
module kth_largest_subset_sum_core #(
    parameter int MAX_ITEMS = kss_pkg::DEF_MAX_ITEMS,
    parameter int MAX_RANK  = kss_pkg::DEF_MAX_RANK
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [kss_pkg::VALUE_W-1:0]  i_value,
    input  logic        [kss_pkg::RANK_W-1:0]   i_rank,
    input  logic                                i_last,
    output logic                                o_valid,
    output logic signed [kss_pkg::KSUM_W-1:0]   o_kth_sum,
    output logic        [kss_pkg::STATUS_W-1:0] o_status
);

    localparam int VW = kss_pkg::VALUE_W;
    localparam int MA = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = VW + MA;
    localparam int XW = (SW > kss_pkg::KSUM_W) ? SW : kss_pkg::KSUM_W;
    localparam int HA = $clog2(2 * MAX_RANK);
    localparam int HW = HA + 1;
    localparam int EW = SW + CW;
    localparam int RW = kss_pkg::RANK_W;

    kss_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_cnt, n_cnt;
    logic [SW-1:0] r_pos_total, n_pos_total;
    logic          r_ovf, n_ovf;
    logic [RW-1:0] r_rank, n_rank;
    logic          r_last, n_last;
    logic [VW-1:0] r_v, n_v;
    logic [CW-1:0] r_j, n_j;
    logic [HW-1:0] r_size, n_size;
    logic [RW-1:0] r_pops, n_pops;
    logic [EW-1:0] r_node, n_node;
    logic [EW-1:0] r_bnode, n_bnode;
    logic [EW-1:0] r_top, n_top;
    logic [HW-1:0] r_i, n_i;
    logic [VW-1:0] r_mcur, n_mcur;
    logic          r_up_pend, n_up_pend;
    logic          r_valid, n_valid;
    logic [kss_pkg::KSUM_W-1:0]   r_kth, n_kth;
    logic [kss_pkg::STATUS_W-1:0] r_status, n_status;

    logic [VW-1:0] r_mag [MAX_ITEMS];
    logic [VW-1:0] r_mag_rd;
    logic          mag_we;
    logic [MA-1:0] mag_wa;
    logic [VW-1:0] mag_wd;
    logic [MA-1:0] mag_ra;

    logic          heap_we;
    logic [HA-1:0] heap_wa;
    logic [EW-1:0] heap_wd;
    logic [HA-1:0] heap_ra_a;
    logic [HA-1:0] heap_ra_b;
    logic [EW-1:0] heap_rd_a;
    logic [EW-1:0] heap_rd_b;

    logic [VW-1:0] in_mag;
    logic [SW:0]   sum_a;
    logic [SW:0]   sum_b;
    logic [HW:0]   dn_c;
    logic [HW:0]   dn_c2;
    logic [EW-1:0] dn_sel;
    logic [HW-1:0] dn_sel_idx;
    logic [HW:0]   dn_next;
    logic [HW-1:0] up_p;
    logic [HW-1:0] up_pp;
    logic [63:0]   subset_cnt;
    logic          rank_bad;
    logic          rank_big;
    logic [XW-1:0] kth_full;

    kss_heap_ram #(
        .AW(HA),
        .DW(EW)
    ) u_heap (
        .i_clk  (i_clk),
        .i_we   (heap_we),
        .i_wa   (heap_wa),
        .i_wd   (heap_wd),
        .i_ra_a (heap_ra_a),
        .i_ra_b (heap_ra_b),
        .o_rd_a (heap_rd_a),
        .o_rd_b (heap_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (mag_we) begin
            r_mag[mag_wa] <= mag_wd;
        end
        r_mag_rd <= r_mag[mag_ra];
    end

    assign in_mag     = i_value[VW-1] ? (~i_value + 1'b1) : i_value;
    assign sum_a      = (SW+1)'(r_top[EW-1:CW]) + (SW+1)'(r_mag_rd);
    assign sum_b      = (SW+1)'(r_top[EW-1:CW]) + (SW+1)'(r_mcur) - (SW+1)'(r_mag_rd);
    assign dn_c       = {r_i, 1'b1};
    assign dn_c2      = dn_c + 1'b1;
    assign up_p       = (r_i - 1'b1) >> 1;
    assign up_pp      = (up_p - 1'b1) >> 1;
    assign subset_cnt = 64'd1 << r_cnt;
    assign rank_bad   = (r_rank == '0) || (32'(r_rank) > 32'(MAX_RANK));
    assign rank_big   = (32'(r_cnt) < 32'd32) && (subset_cnt < 64'(r_rank));
    assign kth_full   = XW'(r_pos_total) - XW'(heap_rd_a[EW-1:CW]);

    always_comb begin
        if ((dn_c2 < (HW+1)'(r_size)) && (heap_rd_b < heap_rd_a)) begin
            dn_sel     = heap_rd_b;
            dn_sel_idx = dn_c2[HW-1:0];
        end else begin
            dn_sel     = heap_rd_a;
            dn_sel_idx = dn_c[HW-1:0];
        end
        dn_next = {dn_sel_idx, 1'b1};
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pos_total = r_pos_total;
        n_ovf       = r_ovf;
        n_rank      = r_rank;
        n_last      = r_last;
        n_v         = r_v;
        n_j         = r_j;
        n_size      = r_size;
        n_pops      = r_pops;
        n_node      = r_node;
        n_bnode     = r_bnode;
        n_top       = r_top;
        n_i         = r_i;
        n_mcur      = r_mcur;
        n_up_pend   = r_up_pend;
        n_valid     = 1'b0;
        n_kth       = r_kth;
        n_status    = r_status;
        mag_we      = 1'b0;
        mag_wa      = '0;
        mag_wd      = r_v;
        mag_ra      = '0;
        heap_we     = 1'b0;
        heap_wa     = '0;
        heap_wd     = r_node;
        heap_ra_a   = '0;
        heap_ra_b   = '0;

        unique case (r_state)
            kss_pkg::S_IDLE: begin
                if (start) begin
                    n_rank = i_rank;
                    n_last = i_last;
                    if (r_cnt != CW'(MAX_ITEMS)) begin
                        n_pos_total = r_pos_total + (i_value[VW-1] ? '0 : SW'(i_value));
                        n_v   = in_mag;
                        n_j   = r_cnt;
                        n_cnt = r_cnt + 1'b1;
                        if (r_cnt == '0) begin
                            mag_we  = 1'b1;
                            mag_wa  = '0;
                            mag_wd  = in_mag;
                            n_state = i_last ? kss_pkg::S_CHECK : kss_pkg::S_IDLE;
                        end else begin
                            mag_ra  = MA'(r_cnt - 1'b1);
                            n_state = kss_pkg::S_INS_CMP;
                        end
                    end else begin
                        n_ovf   = 1'b1;
                        n_state = i_last ? kss_pkg::S_CHECK : kss_pkg::S_IDLE;
                    end
                end
            end
            kss_pkg::S_INS_CMP: begin
                mag_we = 1'b1;
                mag_wa = MA'(r_j);
                if (r_mag_rd > r_v) begin
                    mag_wd = r_mag_rd;
                    n_j    = r_j - 1'b1;
                    if (r_j == CW'(1)) begin
                        n_state = kss_pkg::S_INS_WR;
                    end else begin
                        mag_ra = MA'(r_j - CW'(2));
                    end
                end else begin
                    mag_wd  = r_v;
                    n_state = r_last ? kss_pkg::S_CHECK : kss_pkg::S_IDLE;
                end
            end
            kss_pkg::S_INS_WR: begin
                mag_we  = 1'b1;
                mag_wa  = MA'(r_j);
                mag_wd  = r_v;
                n_state = r_last ? kss_pkg::S_CHECK : kss_pkg::S_IDLE;
            end
            kss_pkg::S_CHECK: begin
                if (r_ovf || rank_bad || rank_big) begin
                    n_valid = 1'b1;
                    n_kth   = '0;
                    if (r_ovf) begin
                        n_status = kss_pkg::ST_TOO_MANY;
                    end else if (rank_bad) begin
                        n_status = kss_pkg::ST_RANK_RANGE;
                    end else begin
                        n_status = kss_pkg::ST_RANK_SUBSETS;
                    end
                    n_cnt       = '0;
                    n_pos_total = '0;
                    n_ovf       = 1'b0;
                    n_size      = '0;
                    n_state     = kss_pkg::S_IDLE;
                end else begin
                    heap_we = 1'b1;
                    heap_wa = '0;
                    heap_wd = '0;
                    n_size  = HW'(1);
                    n_pops  = r_rank - 1'b1;
                    n_state = kss_pkg::S_POP_RD;
                end
            end
            kss_pkg::S_POP_RD: begin
                if (r_size == '0) begin
                    n_valid     = 1'b1;
                    n_kth       = '0;
                    n_status    = kss_pkg::ST_RANK_SUBSETS;
                    n_cnt       = '0;
                    n_pos_total = '0;
                    n_ovf       = 1'b0;
                    n_state     = kss_pkg::S_IDLE;
                end else begin
                    heap_ra_a = '0;
                    if (r_pops == '0) begin
                        n_state = kss_pkg::S_FIN;
                    end else begin
                        n_pops  = r_pops - 1'b1;
                        n_state = kss_pkg::S_POP_TOP;
                    end
                end
            end
            kss_pkg::S_POP_TOP: begin
                n_top = heap_rd_a;
                if (heap_rd_a[CW-1:0] < r_cnt) begin
                    mag_ra  = MA'(heap_rd_a[CW-1:0]);
                    n_state = kss_pkg::S_POP_M1;
                end else begin
                    n_size = r_size - 1'b1;
                    if (r_size == HW'(1)) begin
                        n_state = kss_pkg::S_POP_RD;
                    end else begin
                        heap_ra_a = HA'(r_size - 1'b1);
                        n_state   = kss_pkg::S_POP_LAST;
                    end
                end
            end
            kss_pkg::S_POP_LAST: begin
                n_node    = heap_rd_a;
                n_i       = '0;
                n_up_pend = 1'b0;
                heap_ra_a = HA'(1);
                heap_ra_b = HA'(2);
                n_state   = kss_pkg::S_DN;
            end
            kss_pkg::S_POP_M1: begin
                n_mcur = r_mag_rd;
                n_node = {sum_a[SW-1:0], r_top[CW-1:0] + 1'b1};
                n_i    = '0;
                if (r_top[CW-1:0] != '0) begin
                    mag_ra  = MA'(r_top[CW-1:0] - 1'b1);
                    n_state = kss_pkg::S_POP_M2;
                end else begin
                    n_up_pend = 1'b0;
                    heap_ra_a = HA'(1);
                    heap_ra_b = HA'(2);
                    n_state   = kss_pkg::S_DN;
                end
            end
            kss_pkg::S_POP_M2: begin
                n_bnode   = {sum_b[SW-1:0], r_top[CW-1:0] + 1'b1};
                n_up_pend = 1'b1;
                heap_ra_a = HA'(1);
                heap_ra_b = HA'(2);
                n_state   = kss_pkg::S_DN;
            end
            kss_pkg::S_DN: begin
                heap_we = 1'b1;
                heap_wa = HA'(r_i);
                if ((dn_c < (HW+1)'(r_size)) && (dn_sel < r_node)) begin
                    heap_wd   = dn_sel;
                    n_i       = dn_sel_idx;
                    heap_ra_a = HA'(dn_next);
                    heap_ra_b = HA'(dn_next + 1'b1);
                end else begin
                    heap_wd = r_node;
                    if (r_up_pend) begin
                        n_node  = r_bnode;
                        n_i     = r_size;
                        n_size  = r_size + 1'b1;
                        n_state = kss_pkg::S_UP_RD;
                    end else begin
                        n_state = kss_pkg::S_POP_RD;
                    end
                end
            end
            kss_pkg::S_UP_RD: begin
                if (r_i == '0) begin
                    n_state = kss_pkg::S_UP_WR;
                end else begin
                    heap_ra_a = HA'(up_p);
                    n_state   = kss_pkg::S_UP;
                end
            end
            kss_pkg::S_UP: begin
                heap_we = 1'b1;
                heap_wa = HA'(r_i);
                if (r_node < heap_rd_a) begin
                    heap_wd = heap_rd_a;
                    n_i     = up_p;
                    if (up_p == '0) begin
                        n_state = kss_pkg::S_UP_WR;
                    end else begin
                        heap_ra_a = HA'(up_pp);
                    end
                end else begin
                    heap_wd = r_node;
                    n_state = kss_pkg::S_POP_RD;
                end
            end
            kss_pkg::S_UP_WR: begin
                heap_we = 1'b1;
                heap_wa = HA'(r_i);
                heap_wd = r_node;
                n_state = kss_pkg::S_POP_RD;
            end
            kss_pkg::S_FIN: begin
                n_valid     = 1'b1;
                n_kth       = kth_full[kss_pkg::KSUM_W-1:0];
                n_status    = kss_pkg::ST_OK;
                n_cnt       = '0;
                n_pos_total = '0;
                n_ovf       = 1'b0;
                n_size      = '0;
                n_state     = kss_pkg::S_IDLE;
            end
            default: begin
                n_state = kss_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kss_pkg::S_IDLE;
            r_cnt       <= '0;
            r_pos_total <= '0;
            r_ovf       <= 1'b0;
            r_size      <= '0;
            r_pops      <= '0;
            r_up_pend   <= 1'b0;
            r_valid     <= 1'b0;
            r_status    <= kss_pkg::ST_OK;
            r_kth       <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pos_total <= n_pos_total;
            r_ovf       <= n_ovf;
            r_size      <= n_size;
            r_pops      <= n_pops;
            r_up_pend   <= n_up_pend;
            r_valid     <= n_valid;
            r_status    <= n_status;
            r_kth       <= n_kth;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rank  <= n_rank;
        r_last  <= n_last;
        r_v     <= n_v;
        r_j     <= n_j;
        r_node  <= n_node;
        r_bnode <= n_bnode;
        r_top   <= n_top;
        r_i     <= n_i;
        r_mcur  <= n_mcur;
    end

    assign busy      = (r_state != kss_pkg::S_IDLE);
    assign o_valid   = r_valid;
    assign o_kth_sum = r_kth;
    assign o_status  = r_status;

endmodule

// ===== rtl/core/kss_heap_ram.sv =====
// kss_heap_ram: heap entry memory, one write port and two registered read ports.
// no dependencies; widths come from the core's parameters.
module kss_heap_ram #(
    parameter int AW = 12,
    parameter int DW = 53
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wa,
    input  logic [DW-1:0] i_wd,
    input  logic [AW-1:0] i_ra_a,
    input  logic [AW-1:0] i_ra_b,
    output logic [DW-1:0] o_rd_a,
    output logic [DW-1:0] o_rd_b
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rd_a;
    logic [DW-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        r_rd_a <= r_mem[i_ra_a];
        r_rd_b <= r_mem[i_ra_b];
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

// ===== verif/kss_checker.sv =====
`timescale 1ns / 1ps
// kss_checker: watches the transaction and result channels of the kth largest
// subset sum core, predicts each result and compares it. depends on kss_pkg.
module kss_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic signed [kss_pkg::VALUE_W-1:0]  i_value,
    input  logic        [kss_pkg::RANK_W-1:0]   i_rank,
    input  logic                                i_last,
    input  logic                                o_valid,
    input  logic signed [kss_pkg::KSUM_W-1:0]   o_kth_sum,
    input  logic        [kss_pkg::STATUS_W-1:0] o_status,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_sets_ok,
    output int                                  o_sets_err
);

    localparam int HEAP_DEPTH = 2 * kss_pkg::DEF_MAX_RANK + 2;

    typedef struct {
        logic [kss_pkg::KSUM_W-1:0] kth_sum;
        kss_pkg::t_status           status;
    } t_answer;

    t_answer           answers_due[$];
    int unsigned       mag_q[$];
    int unsigned       loaded;
    longint unsigned   pos_total;
    bit                dropped;
    longint unsigned   hsum [HEAP_DEPTH];
    int unsigned       hidx [HEAP_DEPTH];
    int unsigned       hcount;

    function automatic bit node_lt(longint unsigned sa, int unsigned pa,
                                   longint unsigned sb, int unsigned pb);
        return (sa != sb) ? (sa < sb) : (pa < pb);
    endfunction

    task automatic heap_insert(longint unsigned s, int unsigned p);
        int unsigned i;
        int unsigned up;
        if (hcount >= HEAP_DEPTH) return;
        i = hcount;
        hcount++;
        while (i > 0) begin
            up = (i - 1) / 2;
            if (!node_lt(s, p, hsum[up], hidx[up])) break;
            hsum[i] = hsum[up];
            hidx[i] = hidx[up];
            i = up;
        end
        hsum[i] = s;
        hidx[i] = p;
    endtask

    task automatic heap_drop_min();
        int unsigned i;
        int unsigned c;
        longint unsigned s;
        int unsigned p;
        i = 0;
        if (hcount == 0) return;
        hcount--;
        if (hcount == 0) return;
        s = hsum[hcount];
        p = hidx[hcount];
        forever begin
            c = 2 * i + 1;
            if (c >= hcount) break;
            if (c + 1 < hcount && node_lt(hsum[c+1], hidx[c+1], hsum[c], hidx[c])) c++;
            if (!node_lt(hsum[c], hidx[c], s, p)) break;
            hsum[i] = hsum[c];
            hidx[i] = hidx[c];
            i = c;
        end
        hsum[i] = s;
        hidx[i] = p;
    endtask

    // k-th smallest subset sum of the sorted magnitudes, then the answer
    task automatic predict_set(input logic [kss_pkg::RANK_W-1:0] k, output t_answer ans);
        longint unsigned top_s;
        int unsigned     top_p;
        int unsigned     n;
        ans.kth_sum = '0;
        ans.status  = kss_pkg::ST_OK;
        n = loaded;
        if (dropped) begin
            ans.status = kss_pkg::ST_TOO_MANY;
        end else if (k == 0 || k > kss_pkg::DEF_MAX_RANK) begin
            ans.status = kss_pkg::ST_RANK_RANGE;
        end else if (n < 32 && (64'd1 << n) < k) begin
            ans.status = kss_pkg::ST_RANK_SUBSETS;
        end else begin
            mag_q.sort();
            hcount = 0;
            heap_insert(0, 0);
            for (int j = 1; j < k; j++) begin
                if (hcount == 0) break;
                top_s = hsum[0];
                top_p = hidx[0];
                heap_drop_min();
                if (top_p < n) begin
                    heap_insert(top_s + mag_q[top_p], top_p + 1);
                    if (top_p > 0)
                        heap_insert(top_s - mag_q[top_p-1] + mag_q[top_p], top_p + 1);
                end
            end
            if (hcount > 0) ans.kth_sum = kss_pkg::KSUM_W'(pos_total - hsum[0]);
            else ans.status = kss_pkg::ST_RANK_SUBSETS;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_sets_ok    = 0;
        o_sets_err   = 0;
        loaded       = 0;
        pos_total    = 0;
        dropped      = 0;
        hcount       = 0;
    end

    assign o_pending = answers_due.size();

    always @(posedge i_clk) begin
        t_answer exp_ans;
        t_answer new_ans;
        logic [31:0] v;
        if (i_rst_n) begin
            if (o_valid) begin
                if (answers_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result: kth_sum %0d status %0d",
                                 o_kth_sum, o_status);
                end else begin
                    exp_ans = answers_due.pop_front();
                    if (o_kth_sum !== exp_ans.kth_sum || o_status !== exp_ans.status) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: kth_sum exp %0d got %0d, status exp %0d got %0d",
                                     $signed(exp_ans.kth_sum), o_kth_sum,
                                     exp_ans.status, o_status);
                    end
                end
            end
            if (start && !busy) begin
                v = i_value;
                if (loaded < kss_pkg::DEF_MAX_ITEMS) begin
                    if (!v[31] && v != 0) begin
                        pos_total += v;
                        mag_q.push_back(v);
                    end else begin
                        mag_q.push_back(-v);
                    end
                    loaded++;
                end else begin
                    dropped = 1;
                end
                if (i_last) begin
                    predict_set(i_rank, new_ans);
                    answers_due.push_back(new_ans);
                    if (new_ans.status == kss_pkg::ST_OK) o_sets_ok++;
                    else o_sets_err++;
                    mag_q.delete();
                    loaded    = 0;
                    pos_total = 0;
                    dropped   = 0;
                    hcount    = 0;
                end
            end
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// testbench: drives data sets into the kth largest subset sum core and gives
// the verdict. depends on kss_pkg, kss_checker and the core.
module testbench;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                start;
    logic                                busy;
    logic signed [kss_pkg::VALUE_W-1:0]  i_value;
    logic        [kss_pkg::RANK_W-1:0]   i_rank;
    logic                                i_last;
    logic                                o_valid;
    logic signed [kss_pkg::KSUM_W-1:0]   o_kth_sum;
    logic        [kss_pkg::STATUS_W-1:0] o_status;
    int fail_count, pending, sets_ok, sets_err;
    int items_sent;
    longint cycles;
    bit quiet_phase;

    kth_largest_subset_sum_core DUT (.*);

    kss_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_value, .i_rank, .i_last,
        .o_valid, .o_kth_sum, .o_status,
        .o_fail_count(fail_count), .o_pending(pending),
        .o_sets_ok(sets_ok), .o_sets_err(sets_err)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 40000000) begin
                $display("timeout");
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (quiet_phase) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // one transaction; start stays high into the next one when no gap
    task automatic send_item(logic [31:0] v, logic [kss_pkg::RANK_W-1:0] k, logic lst);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            start = 0;
        end
        @(negedge i_clk);
        start   = 1;
        i_value = v;
        i_rank  = k;
        i_last  = lst;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    task automatic send_set(int n, int kind, logic [kss_pkg::RANK_W-1:0] k);
        logic [31:0] v;
        for (int j = 0; j < n; j++) begin
            case (kind)
                0: v = $urandom();
                1: v = $urandom_range(0, 20) - 10;
                2: v = j + 1;
                default: v = $urandom_range(0, 2000) - 1000;
            endcase
            send_item(v, k, j == n - 1);
        end
    endtask

    initial begin
        longint lim;
        int n, r;
        logic [kss_pkg::RANK_W-1:0] k;
        start = 0;
        i_value = '0;
        i_rank = '0;
        i_last = 0;
        i_rst_n = 0;
        items_sent = 0;
        quiet_phase = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // extremes, zero, rank edges, rank beyond the subsets
        send_item(32'h7fffffff, 1, 0);
        send_item(32'h80000000, 1, 0);
        send_item(32'h00000000, 1, 0);
        send_item(32'hffffffff, 1, 0);
        send_item(32'h00000001, 16, 1);
        send_item(32'h00000005, 2, 1);
        send_item(32'hfffffffb, 2, 1);
        send_item(32'h00000005, 3, 1);
        send_item(32'h00000003, 0, 1);
        send_item(32'h00000003, 2049, 1);
        send_item(32'h00000003, 4095, 1);
        send_item(32'h7fffffff, 1, 0);
        send_item(32'h7fffffff, 4, 1);
        send_item(32'h80000000, 1, 0);
        send_item(32'h80000000, 4, 1);
        send_set(11, 0, 2048);
        send_set(4, 1, 16);

        // pause until the core has answered everything
        @(negedge i_clk);
        start = 0;
        wait (pending == 0);

        while (items_sent < 870) begin
            if ($urandom_range(0, 9) == 0) quiet_phase = ~quiet_phase;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 14);
            lim = (n < 12) ? (64'd1 << n) : 4096;
            r = $urandom_range(0, 99);
            if (r < 72) k = $urandom_range(1, (lim < 64) ? lim : 64);
            else if (r < 75) k = $urandom_range(1, 2048);
            else if (r < 85 && lim < 2048) k = $urandom_range(lim + 1, 2048);
            else k = $urandom_range(0, 4095);
            send_set(n, $urandom_range(0, 3), k);
        end
        // a full store plus one item too many
        quiet_phase = 0;
        send_set(1025, 2, 5);
        send_set(3, 0, 8);

        @(negedge i_clk);
        start = 0;
        wait (pending == 0);
        repeat (2000) @(posedge i_clk);
        $display("%0d items in %0d data sets, %0d answered ok and %0d with an error status",
                 items_sent, sets_ok + sets_err, sets_ok, sets_err);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/kss_pkg.sv
rtl/core/kss_heap_ram.sv
rtl/core/kth_largest_subset_sum_core.sv
verif/kss_checker.sv
verif/testbench.sv
